/* src/mcev_pkg.sv */
// Shared constants, controller/datapath interface structs and the host level table
// for the multi-channel encoder volume block. No dependencies.
package mcev_pkg;

    localparam int NUM_CHANNELS = 5;
    localparam int PIN_W        = 5;
    localparam int ACTIVE_CH    = (NUM_CHANNELS < PIN_W) ? NUM_CHANNELS : PIN_W;
    localparam int IDX_W        = (ACTIVE_CH > 1) ? $clog2(ACTIVE_CH) : 1;
    localparam int CHAN_W       = 3;
    localparam int VOL_W        = 7;
    localparam int HOST_W       = 10;
    localparam int VOL_MAX      = 100;
    localparam int HOST_MAX     = 1023;
    localparam int STEP_RESET   = 5;
    localparam int LUT_DEPTH    = 1 << VOL_W;

    typedef logic [LUT_DEPTH-1:0][HOST_W-1:0] host_lut_t;

    typedef struct packed {
        logic capture;   // take the offered sample word
        logic step;      // process the current channel and advance
    } ctrl_cmd_t;

    typedef struct packed {
        logic primed;
        logic last_chan;
        logic out_free;
    } dp_status_t;

    // volume*1023/100 truncated, built by repeated subtraction at elaboration
    function automatic host_lut_t build_host_lut();
        host_lut_t   t;
        int unsigned acc;
        int unsigned q;
        acc = 0;
        q   = 0;
        for (int v = 0; v < LUT_DEPTH; v++) begin
            t[v] = HOST_W'(q);
            acc  = acc + HOST_MAX;
            for (int k = 0; k < 11; k++) begin
                if (acc >= VOL_MAX) begin
                    acc = acc - VOL_MAX;
                    q   = q + 1;
                end
            end
        end
        return t;
    endfunction

    localparam host_lut_t HOST_LUT = build_host_lut();

endpackage

/* src/multi_channel_encoder_volume_core.sv */
// Top level of the multi-channel rotary encoder volume block.
// Depends on mcev_pkg, mcev_ctrl and mcev_datapath.
//
//   channel   handshake           payload
//   s_*       s_valid / s_ready   pin_a, pin_b, pin_switch (one sample word)
//   m_*       m_valid / m_ready   channel, volume, muted, host_level, last
//   cfg_*     cfg_wr_en           cfg_wr_data -> step size
//
// A sample word is taken in ST_IDLE, then the channels are walked one per cycle while
// the output register is free; s_ready stays low until the walk has ended.
// Synchronous active-low reset: volumes 100, unmuted, step 5; the first word
// after reset only primes the edge detectors and produces no output.
// While a result word waits with m_ready low, the walk holds at the next channel.
module multi_channel_encoder_volume_core
    import mcev_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [VOL_W-1:0]   cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PIN_W-1:0]   s_pin_a,
    input  logic [PIN_W-1:0]   s_pin_b,
    input  logic [PIN_W-1:0]   s_pin_switch,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAN_W-1:0]  m_channel,
    output logic [VOL_W-1:0]   m_volume,
    output logic               m_muted,
    output logic [HOST_W-1:0]  m_host_level,
    output logic               m_last
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mcev_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mcev_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_pin_a      (s_pin_a),
        .s_pin_b      (s_pin_b),
        .s_pin_switch (s_pin_switch),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_channel    (m_channel),
        .m_volume     (m_volume),
        .m_muted      (m_muted),
        .m_host_level (m_host_level),
        .m_last       (m_last)
    );

endmodule

/* src/mcev_ctrl.sv */
// Sequencer for the encoder volume block: accepts a sample word, then walks the channels.
// Depends on mcev_pkg.
module mcev_ctrl
    import mcev_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.step    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    // first word after reset only primes the edge detectors
                    if (status.primed) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (status.out_free) begin
                    cmd.step = 1'b1;
                    if (status.last_chan) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_capture_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> state_reg == ST_IDLE)
        else $error("capture outside idle");

    a_step_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (state_reg == ST_SCAN) && status.out_free)
        else $error("step while output blocked or not scanning");

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state not one-hot");

endmodule

/* src/mcev_datapath.sv */
// Per-channel encoder state, volume update, host level lookup and output register.
// Depends on mcev_pkg.
module mcev_datapath
    import mcev_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [VOL_W-1:0]   cfg_wr_data,
    input  logic [PIN_W-1:0]   s_pin_a,
    input  logic [PIN_W-1:0]   s_pin_b,
    input  logic [PIN_W-1:0]   s_pin_switch,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAN_W-1:0]  m_channel,
    output logic [VOL_W-1:0]   m_volume,
    output logic               m_muted,
    output logic [HOST_W-1:0]  m_host_level,
    output logic               m_last
);

    logic [VOL_W-1:0]                  step_reg;
    logic                              primed_reg;
    logic [ACTIVE_CH-1:0]              prev_a_reg, prev_sw_reg, mute_reg;
    logic [ACTIVE_CH-1:0][VOL_W-1:0]   level_reg;
    logic [ACTIVE_CH-1:0]              a_reg, b_reg, sw_reg, mask_reg;
    logic [IDX_W-1:0]                  idx_reg;

    logic                              out_valid_reg;
    logic [CHAN_W-1:0]                 out_chan_reg;
    logic [VOL_W-1:0]                  out_vol_reg;
    logic                              out_mute_reg;
    logic [HOST_W-1:0]                 out_host_reg;
    logic                              out_last_reg;

    logic                              ca, cb, cs, a_edge, sw_edge, mute_next;
    logic [VOL_W:0]                    vol_sum;
    logic [VOL_W-1:0]                  vol_next;
    logic [ACTIVE_CH-1:0]              edge_mask;
    logic                              load_out;

    assign edge_mask = (s_pin_a[ACTIVE_CH-1:0] ^ prev_a_reg)
                     | (s_pin_switch[ACTIVE_CH-1:0] ^ prev_sw_reg);

    assign ca      = a_reg[idx_reg];
    assign cb      = b_reg[idx_reg];
    assign cs      = sw_reg[idx_reg];
    assign a_edge  = ca ^ prev_a_reg[idx_reg];
    assign sw_edge = cs ^ prev_sw_reg[idx_reg];
    assign vol_sum = {1'b0, level_reg[idx_reg]} + {1'b0, step_reg};

    always_comb begin
        vol_next = level_reg[idx_reg];
        if (a_edge) begin
            if (cb != ca) begin
                vol_next = (vol_sum > (VOL_W+1)'(VOL_MAX)) ? VOL_W'(VOL_MAX)
                                                           : vol_sum[VOL_W-1:0];
            end else begin
                vol_next = (level_reg[idx_reg] < step_reg) ? '0
                                                           : level_reg[idx_reg] - step_reg;
            end
        end
    end

    // only a press (falling switch level) toggles mute
    assign mute_next = mute_reg[idx_reg] ^ (sw_edge & ~cs);
    assign load_out  = cmd.step & mask_reg[0];

    assign status.primed    = primed_reg;
    assign status.last_chan = (idx_reg == IDX_W'(ACTIVE_CH - 1));
    assign status.out_free  = ~out_valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= VOL_W'(STEP_RESET);
            primed_reg  <= 1'b0;
            prev_a_reg  <= '0;
            prev_sw_reg <= '1;
            mute_reg    <= '0;
            for (int i = 0; i < ACTIVE_CH; i++) begin
                level_reg[i] <= VOL_W'(VOL_MAX);
            end
            idx_reg     <= '0;
            mask_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            if (cmd.capture) begin
                idx_reg  <= '0;
                mask_reg <= edge_mask;
                if (!primed_reg) begin
                    prev_a_reg  <= s_pin_a[ACTIVE_CH-1:0];
                    prev_sw_reg <= s_pin_switch[ACTIVE_CH-1:0];
                    primed_reg  <= 1'b1;
                end
            end
            if (cmd.step) begin
                level_reg[idx_reg]   <= vol_next;
                mute_reg[idx_reg]    <= mute_next;
                prev_a_reg[idx_reg]  <= ca;
                prev_sw_reg[idx_reg] <= cs;
                mask_reg             <= mask_reg >> 1;
                if (!status.last_chan) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    // sample word, held for the channel walk
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            a_reg  <= s_pin_a[ACTIVE_CH-1:0];
            b_reg  <= s_pin_b[ACTIVE_CH-1:0];
            sw_reg <= s_pin_switch[ACTIVE_CH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_chan_reg <= CHAN_W'(idx_reg);
            out_vol_reg  <= vol_next;
            out_mute_reg <= mute_next;
            out_host_reg <= mute_next ? '0 : HOST_LUT[vol_next];
            out_last_reg <= ((mask_reg >> 1) == '0);
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_channel    = out_chan_reg;
    assign m_volume     = out_vol_reg;
    assign m_muted      = out_mute_reg;
    assign m_host_level = out_host_reg;
    assign m_last       = out_last_reg;

    a_vol_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_volume <= VOL_W'(VOL_MAX))
        else $error("volume above full scale");

    a_mute_host: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_muted) |-> m_host_level == '0)
        else $error("muted channel with nonzero host level");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_W'(ACTIVE_CH - 1))
        else $error("channel index out of range");

    a_last_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && ((mask_reg >> 1) == '0)) |=> mask_reg == '0)
        else $error("edges left after last word");

endmodule
